>>> src/fdct_pkg.sv
package fdct_pkg;

    localparam int FracBitsDef = 11;
    localparam int RowW = 16;
    localparam int WideW = 24;

    typedef struct packed {
        logic [7:0] sample_7;
        logic [7:0] sample_6;
        logic [7:0] sample_5;
        logic [7:0] sample_4;
        logic [7:0] sample_3;
        logic [7:0] sample_2;
        logic [7:0] sample_1;
        logic [7:0] sample_0;
    } t_in_beat;

    typedef struct packed {
        logic        last_row;
        logic [2:0]  freq_row;
        logic signed [11:0] coef_7;
        logic signed [11:0] coef_6;
        logic signed [11:0] coef_5;
        logic signed [11:0] coef_4;
        logic signed [11:0] coef_3;
        logic signed [11:0] coef_2;
        logic signed [11:0] coef_1;
        logic signed [11:0] coef_0;
    } t_out_beat;

    typedef logic signed [WideW-1:0] t_vec8 [8];

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COL,
        ST_EMIT
    } t_back_state;

    localparam logic [63:0] K30_C4   = 64'd759250124;
    localparam logic [63:0] K30_C6   = 64'd410903207;
    localparam logic [63:0] K30_C2M6 = 64'd581104887;
    localparam logic [63:0] K30_C2P6 = 64'd1402911300;

    function automatic logic [63:0] aan_scale28(input int k);
        case (k)
            0: return 64'd268435456;
            1: return 64'd372330673;
            2: return 64'd350727825;
            3: return 64'd315646704;
            4: return 64'd268435456;
            5: return 64'd210908384;
            6: return 64'd145276222;
            default: return 64'd74061176;
        endcase
    endfunction

    function automatic logic [19:0] kconst(input logic [63:0] k30, input int fb);
        logic [63:0] t;
        t = k30 >> (30 - fb);
        return t[19:0];
    endfunction

    // floor(2^(fb+56) / (8*a[u]*a[v])), elaboration only
    function automatic logic [31:0] descale(input int u, input int v, input int fb);
        logic [127:0] d;
        logic [127:0] r;
        logic [127:0] q;
        d = 128'd8 * aan_scale28(u) * aan_scale28(v);
        r = 128'd0;
        q = 128'd0;
        for (int b = fb + 56; b >= 0; b--) begin
            r = {r[126:0], (b == fb + 56) ? 1'b1 : 1'b0};
            q = {q[126:0], 1'b0};
            if (r >= d) begin
                r = r - d;
                q[0] = 1'b1;
            end
        end
        return q[31:0];
    endfunction

endpackage

>>> src/fdct_aan8.sv
module fdct_aan8 #(
    parameter int FRAC_BITS = fdct_pkg::FracBitsDef
) (
    input  logic                 i_clk,
    input  fdct_pkg::t_vec8      i_d,
    output fdct_pkg::t_vec8      o_d
);
    import fdct_pkg::*;

    localparam logic signed [20:0] C4   = {1'b0, kconst(K30_C4, FRAC_BITS)};
    localparam logic signed [20:0] C6   = {1'b0, kconst(K30_C6, FRAC_BITS)};
    localparam logic signed [20:0] C2M6 = {1'b0, kconst(K30_C2M6, FRAC_BITS)};
    localparam logic signed [20:0] C2P6 = {1'b0, kconst(K30_C2P6, FRAC_BITS)};

    logic signed [WideW-1:0] r_e0, r_e1, r_e2, r_e3, r_d07, r_o0, r_o1, r_o2;
    logic signed [WideW-1:0] r_m, r_r, r_p, r_q, r_h;
    logic signed [WideW-1:0] r_a0, r_a4, r_a3, r_d07b;
    logic signed [WideW-1:0] n_s07, n_s16, n_s25, n_s34;
    logic signed [44:0] n_pm, n_pr, n_pp, n_pq, n_ph;

    always_comb begin
        n_s07 = i_d[0] + i_d[7];
        n_s16 = i_d[1] + i_d[6];
        n_s25 = i_d[2] + i_d[5];
        n_s34 = i_d[3] + i_d[4];
        n_pm = (r_e2 + r_e3) * C4;
        n_pr = (r_o0 - r_o2) * C6;
        n_pp = r_o0 * C2M6;
        n_pq = r_o2 * C2P6;
        n_ph = r_o1 * C4;
    end

    always_ff @(posedge i_clk) begin
        r_e0  <= n_s07 + n_s34;
        r_e3  <= n_s07 - n_s34;
        r_e1  <= n_s16 + n_s25;
        r_e2  <= n_s16 - n_s25;
        r_d07 <= i_d[0] - i_d[7];
        r_o0  <= (i_d[3] - i_d[4]) + (i_d[2] - i_d[5]);
        r_o1  <= (i_d[2] - i_d[5]) + (i_d[1] - i_d[6]);
        r_o2  <= (i_d[1] - i_d[6]) + (i_d[0] - i_d[7]);
        r_m   <= WideW'(n_pm >>> FRAC_BITS);
        r_r   <= WideW'(n_pr >>> FRAC_BITS);
        r_p   <= WideW'(n_pp >>> FRAC_BITS);
        r_q   <= WideW'(n_pq >>> FRAC_BITS);
        r_h   <= WideW'(n_ph >>> FRAC_BITS);
        r_a0  <= r_e0 + r_e1;
        r_a4  <= r_e0 - r_e1;
        r_a3  <= r_e3;
        r_d07b <= r_d07;
    end

    always_comb begin
        o_d[0] = r_a0;
        o_d[4] = r_a4;
        o_d[2] = r_a3 + r_m;
        o_d[6] = r_a3 - r_m;
        o_d[5] = (r_d07b - r_h) + (r_p + r_r);
        o_d[3] = (r_d07b - r_h) - (r_p + r_r);
        o_d[1] = (r_d07b + r_h) + (r_q + r_r);
        o_d[7] = (r_d07b + r_h) - (r_q + r_r);
    end

endmodule

>>> src/fdct_front.sv
module fdct_front #(
    parameter int FRAC_BITS = fdct_pkg::FracBitsDef
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  fdct_pkg::t_in_beat    i_data,
    output logic                  o_stall,
    input  logic                  i_blk_free,
    output logic                  o_blk_done,
    output logic                  o_wr,
    output logic [2:0]            o_wr_row,
    output fdct_pkg::t_vec8       o_wr_data
);
    import fdct_pkg::*;

    t_vec8 n_d;
    logic [2:0] r_row;
    logic [1:0] r_vld;
    logic [2:0] r_prow [2];
    logic       r_pend;
    logic       acc;

    fdct_aan8 #(.FRAC_BITS(FRAC_BITS)) u_row (
        .i_clk (i_clk),
        .i_d   (n_d),
        .o_d   (o_wr_data)
    );

    // hold the first row of a block until the previous block has reached the store and a bank is free
    assign o_stall = (r_row == 3'd0) && (!i_blk_free || r_pend);
    assign acc = i_valid && !o_stall;

    always_comb begin
        n_d[0] = WideW'(($signed({2'b00, i_data.sample_0}) - 10'sd128) * 4);
        n_d[1] = WideW'(($signed({2'b00, i_data.sample_1}) - 10'sd128) * 4);
        n_d[2] = WideW'(($signed({2'b00, i_data.sample_2}) - 10'sd128) * 4);
        n_d[3] = WideW'(($signed({2'b00, i_data.sample_3}) - 10'sd128) * 4);
        n_d[4] = WideW'(($signed({2'b00, i_data.sample_4}) - 10'sd128) * 4);
        n_d[5] = WideW'(($signed({2'b00, i_data.sample_5}) - 10'sd128) * 4);
        n_d[6] = WideW'(($signed({2'b00, i_data.sample_6}) - 10'sd128) * 4);
        n_d[7] = WideW'(($signed({2'b00, i_data.sample_7}) - 10'sd128) * 4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= 3'd0;
            r_vld  <= 2'b00;
            r_pend <= 1'b0;
        end else begin
            if (acc) begin
                r_row <= r_row + 3'd1;
            end
            r_vld <= {r_vld[0], acc};
            if (acc && (r_row == 3'd7)) begin
                r_pend <= 1'b1;
            end else if (o_blk_done) begin
                r_pend <= 1'b0;
            end
        end
        r_prow[0] <= r_row;
        r_prow[1] <= r_prow[0];
    end

    assign o_wr       = r_vld[1];
    assign o_wr_row   = r_prow[1];
    assign o_blk_done = r_vld[1] && (r_prow[1] == 3'd7);

endmodule

>>> src/fdct_back.sv
module fdct_back #(
    parameter int FRAC_BITS = fdct_pkg::FracBitsDef
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [2:0]            i_wr_row,
    input  fdct_pkg::t_vec8       i_wr_data,
    input  logic                  i_blk_done,
    output logic                  o_blk_free,
    output logic                  o_valid,
    output fdct_pkg::t_out_beat   o_data,
    input  logic                  i_stall
);
    import fdct_pkg::*;

    logic signed [WideW-1:0] r_res [8][8];
    logic r_wbank, r_rbank;
    logic [1:0] r_full, n_full;
    t_back_state r_st, n_st;
    logic [3:0] r_cnt, n_cnt;
    logic [1:0] r_cv;
    logic emit_ok;
    logic blk_end;
    t_vec8 n_col, n_colo;

    fdct_aan8 #(.FRAC_BITS(FRAC_BITS)) u_col (
        .i_clk (i_clk),
        .i_d   (n_col),
        .o_d   (n_colo)
    );

    assign o_blk_free = !r_full[0] || !r_full[1];

    // ping-pong transpose store, bank = block parity
    for (genvar k = 0; k < 8; k++) begin : g_row
        logic signed [RowW-1:0] r_line [16];

        always_ff @(posedge i_clk) begin
            if (i_wr && (i_wr_row == 3'(k))) begin
                for (int c = 0; c < 8; c++) begin
                    r_line[{r_wbank, 3'(c)}] <= RowW'(i_wr_data[c]);
                end
            end
        end

        assign n_col[k] = WideW'(r_line[{r_rbank, r_cnt[2:0]}]);
    end

    assign emit_ok = !o_valid || !i_stall;
    assign blk_end = (r_st == ST_EMIT) && emit_ok && (r_cnt == 4'd7);

    // shift columns in during the column pass, shift rows out while emitting
    always_ff @(posedge i_clk) begin
        if (r_cv[1]) begin
            for (int k = 0; k < 8; k++) begin
                for (int j = 0; j < 7; j++) begin
                    r_res[k][j] <= r_res[k][j + 1];
                end
                r_res[k][7] <= n_colo[k];
            end
        end else if ((r_st == ST_EMIT) && emit_ok) begin
            for (int k = 0; k < 7; k++) begin
                r_res[k] <= r_res[k + 1];
            end
        end
    end

    always_comb begin
        n_full = r_full;
        if (i_blk_done) begin
            n_full[r_wbank] = 1'b1;
        end
        if (blk_end) begin
            n_full[r_rbank] = 1'b0;
        end
    end

    always_comb begin
        n_st  = r_st;
        n_cnt = r_cnt;
        case (r_st)
            ST_IDLE: begin
                if (r_full[r_rbank]) begin
                    n_st  = ST_COL;
                    n_cnt = 4'd0;
                end
            end
            ST_COL: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd9) begin
                    n_st  = ST_EMIT;
                    n_cnt = 4'd0;
                end
            end
            ST_EMIT: begin
                if (emit_ok) begin
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd7) begin
                        n_st = ST_IDLE;
                    end
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    localparam int Sh = FRAC_BITS + 2;

    function automatic logic signed [11:0] sat12(input logic signed [42:0] x);
        if (x > 43'sd2047) return 12'sd2047;
        if (x < -43'sd2048) return -12'sd2048;
        return x[11:0];
    endfunction

    function automatic logic signed [18:0] ds_k(input int u, input int v);
        logic [31:0] t;
        t = descale(u, v, FRAC_BITS);
        return $signed({1'b0, t[17:0]});
    endfunction

    logic signed [42:0] n_p [8];
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            case (r_cnt[2:0])
                3'd0: n_p[i] = (r_res[0][i] * ds_k(0, i)) >>> Sh;
                3'd1: n_p[i] = (r_res[0][i] * ds_k(1, i)) >>> Sh;
                3'd2: n_p[i] = (r_res[0][i] * ds_k(2, i)) >>> Sh;
                3'd3: n_p[i] = (r_res[0][i] * ds_k(3, i)) >>> Sh;
                3'd4: n_p[i] = (r_res[0][i] * ds_k(4, i)) >>> Sh;
                3'd5: n_p[i] = (r_res[0][i] * ds_k(5, i)) >>> Sh;
                3'd6: n_p[i] = (r_res[0][i] * ds_k(6, i)) >>> Sh;
                default: n_p[i] = (r_res[0][i] * ds_k(7, i)) >>> Sh;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            r_cnt   <= 4'd0;
            r_wbank <= 1'b0;
            r_rbank <= 1'b0;
            r_full  <= 2'b00;
            r_cv    <= 2'b00;
            o_valid <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_cnt  <= n_cnt;
            r_cv   <= {r_cv[0], (r_st == ST_COL) && (r_cnt < 4'd8)};
            r_full <= n_full;
            if (i_blk_done) begin
                r_wbank <= !r_wbank;
            end
            if (blk_end) begin
                r_rbank <= !r_rbank;
            end
            if (emit_ok) begin
                o_valid <= (r_st == ST_EMIT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == ST_EMIT && emit_ok) begin
            o_data.coef_0   <= sat12(n_p[0]);
            o_data.coef_1   <= sat12(n_p[1]);
            o_data.coef_2   <= sat12(n_p[2]);
            o_data.coef_3   <= sat12(n_p[3]);
            o_data.coef_4   <= sat12(n_p[4]);
            o_data.coef_5   <= sat12(n_p[5]);
            o_data.coef_6   <= sat12(n_p[6]);
            o_data.coef_7   <= sat12(n_p[7]);
            o_data.freq_row <= r_cnt[2:0];
            o_data.last_row <= (r_cnt == 4'd7);
        end
    end

endmodule

>>> src/fdct_8x8_fixed_point.sv
// 8x8 forward DCT, fixed point.
// Input channel: i_valid / o_stall carrying one row of eight samples per beat.
// Output channel: o_valid / i_stall carrying one coefficient row per beat,
// freq_row 0..7, last_row set on the eighth.
// Front: level shift and row butterfly, one row a cycle unless stalled,
// written into a two-bank transpose store. Back: column butterfly over eight
// columns, then descale and saturate, one coefficient row a cycle while the
// output is not stalled.
// Throughput: one input row per cycle within a block; the first row of the
// next block waits until the previous block is in the store, and longer if
// neither bank is free. The back works on one block at a time while the
// front fills the other bank.
// Reset clears counters, bank flags and output valid; store contents are
// not cleared.
// A stalled output holds its beat; the back waits and the front stalls once
// both banks hold blocks.
module fdct_8x8_fixed_point #(
    parameter int FRAC_BITS = fdct_pkg::FracBitsDef
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  fdct_pkg::t_in_beat    i_data,
    output logic                  o_stall,
    output logic                  o_valid,
    output fdct_pkg::t_out_beat   o_data,
    input  logic                  i_stall
);
    import fdct_pkg::*;

    logic  blk_free, blk_done, wr;
    logic [2:0] wr_row;
    t_vec8 wr_data;

    fdct_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_data     (i_data),
        .o_stall    (o_stall),
        .i_blk_free (blk_free),
        .o_blk_done (blk_done),
        .o_wr       (wr),
        .o_wr_row   (wr_row),
        .o_wr_data  (wr_data)
    );

    fdct_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (wr),
        .i_wr_row   (wr_row),
        .i_wr_data  (wr_data),
        .i_blk_done (blk_done),
        .o_blk_free (blk_free),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_stall    (i_stall)
    );

endmodule

>>> bench/fdct_checker.sv
`timescale 1ns / 100ps

module fdct_checker
    import fdct_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_beat  i_data,
    input  logic      i_stall,
    input  logic      o_stall,
    input  logic      o_valid,
    input  t_out_beat o_data,
    output int        o_fails,
    output int        o_pending
);

    localparam int FB = FracBitsDef;
    localparam longint KC4   = 64'sd759250124 >>> (30 - FB);
    localparam longint KC6   = 64'sd410903207 >>> (30 - FB);
    localparam longint KC2M6 = 64'sd581104887 >>> (30 - FB);
    localparam longint KC2P6 = 64'sd1402911300 >>> (30 - FB);

    longint    aan_a [8] = '{268435456, 372330673, 350727825, 315646704,
                             268435456, 210908384, 145276222, 74061176};
    longint    gain_tab [64];
    longint    row_store [64];
    int        rows_in;
    t_out_beat coef_rows_q [$];
    int        fails;

    function automatic void aan_fly(inout longint d [8]);
        longint s07, d07, s16, d16, s25, d25, s34, d34, e0, e1, e2, e3;
        longint m, o0, o1, o2, r, p, q, h;
        s07 = d[0] + d[7]; d07 = d[0] - d[7];
        s16 = d[1] + d[6]; d16 = d[1] - d[6];
        s25 = d[2] + d[5]; d25 = d[2] - d[5];
        s34 = d[3] + d[4]; d34 = d[3] - d[4];
        e0 = s07 + s34; e3 = s07 - s34;
        e1 = s16 + s25; e2 = s16 - s25;
        d[0] = e0 + e1;
        d[4] = e0 - e1;
        m = ((e2 + e3) * KC4) >>> FB;
        d[2] = e3 + m;
        d[6] = e3 - m;
        o0 = d34 + d25;
        o1 = d25 + d16;
        o2 = d16 + d07;
        r = ((o0 - o2) * KC6) >>> FB;
        p = ((KC2M6 * o0) >>> FB) + r;
        q = ((KC2P6 * o2) >>> FB) + r;
        h = (o1 * KC4) >>> FB;
        d[5] = d07 - h + p;
        d[3] = d07 - h - p;
        d[1] = d07 + h + q;
        d[7] = d07 + h - q;
    endfunction

    function automatic logic [11:0] clip12(input longint x);
        if (x > 2047) x = 2047;
        if (x < -2048) x = -2048;
        return x[11:0];
    endfunction

    task automatic take_row(input t_in_beat beat);
        longint    line [8];
        longint    col [8];
        longint    blk [64];
        t_out_beat res;
        logic [63:0] bits;
        bits = beat;
        for (int i = 0; i < 8; i++) line[i] = (longint'(bits[i*8 +: 8]) - 128) * 4;
        aan_fly(line);
        for (int i = 0; i < 8; i++) row_store[rows_in*8 + i] = line[i];
        if (rows_in != 7) begin
            rows_in++;
            return;
        end
        rows_in = 0;
        blk = row_store;
        for (int i = 0; i < 8; i++) begin
            for (int k = 0; k < 8; k++) col[k] = blk[k*8 + i];
            aan_fly(col);
            for (int k = 0; k < 8; k++) blk[k*8 + i] = col[k];
        end
        for (int k = 0; k < 8; k++) begin
            logic [99:0] flat;
            for (int i = 0; i < 8; i++)
                flat[i*12 +: 12] = clip12((blk[k*8 + i] * gain_tab[k*8 + i]) >>> (FB + 2));
            flat[96 +: 3] = k[2:0];
            flat[99] = (k == 7);
            res = flat;
            coef_rows_q.push_back(res);
        end
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
        fails++;
    endtask

    initial begin
        logic [127:0] den;
        for (int u = 0; u < 8; u++)
            for (int v = 0; v < 8; v++) begin
                den = 128'd8 * aan_a[u] * aan_a[v];
                gain_tab[u*8 + v] = longint'((128'd1 << (FB + 56)) / den);
            end
        fails = 0;
        rows_in = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_in = 0;
            coef_rows_q.delete();
        end else begin
            if (o_valid && !i_stall) begin
                if (coef_rows_q.size() == 0) begin
                    report("unexpected beat, freq_row", o_data.freq_row, -1);
                end else begin
                    t_out_beat ex;
                    logic [99:0] g, w;
                    ex = coef_rows_q.pop_front();
                    g = o_data;
                    w = ex;
                    for (int i = 0; i < 8; i++)
                        if (g[i*12 +: 12] !== w[i*12 +: 12])
                            report($sformatf("row %0d coef_%0d", ex.freq_row, i),
                                   $signed(g[i*12 +: 12]), $signed(w[i*12 +: 12]));
                    if (o_data.freq_row !== ex.freq_row)
                        report("freq_row", o_data.freq_row, ex.freq_row);
                    if (o_data.last_row !== ex.last_row)
                        report("last_row", o_data.last_row, ex.last_row);
                end
            end
            if (i_valid && !o_stall) take_row(i_data);
        end
        o_fails   <= fails;
        o_pending <= coef_rows_q.size();
    end

endmodule

>>> bench/fdct_8x8_fixed_point_tb.sv
`timescale 1ns / 100ps

module fdct_8x8_fixed_point_tb;
    import fdct_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    t_in_beat  i_data;
    logic      o_stall;
    logic      o_valid;
    t_out_beat o_data;
    logic      i_stall;
    int        fails;
    int        pending;
    logic      quiet;
    logic      hold_off;

    localparam int NumRows = 304;

    fdct_8x8_fixed_point u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    fdct_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_data    (i_data),
        .i_stall   (i_stall),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .o_fails   (fails),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic t_in_beat make_row(input int n);
        logic [63:0] b;
        int blk, r, base;
        blk = n / 8;
        r = n % 8;
        if (blk == 0) b = '0;
        else if (blk == 1) b = '1;
        else if (blk == 2) b = ((r % 2) != 0) ? 64'h00ff00ff00ff00ff : 64'hff00ff00ff00ff00;
        else begin
            case ($urandom_range(3))
                0: b = {$urandom, $urandom};
                1: begin
                    base = $urandom_range(255);
                    for (int i = 0; i < 8; i++)
                        b[i*8 +: 8] = 8'(base + $urandom_range(24) - 12);
                end
                2: for (int i = 0; i < 8; i++)
                        b[i*8 +: 8] = $urandom_range(1) ? 8'hff : 8'h00;
                default: for (int i = 0; i < 8; i++)
                        b[i*8 +: 8] = 8'(i * 32 + r * 4 + $urandom_range(3));
            endcase
        end
        return b;
    endfunction

    // receiver
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_stall <= 1'b1;
                repeat (60) @(posedge i_clk);
                i_stall <= 1'b0;
                wait (!hold_off);
            end else if (!quiet && $urandom_range(3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(2)) @(posedge i_clk);
                @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // sender
    initial begin
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_data   = '0;
        quiet    = 1'b0;
        hold_off = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int n = 0; n < NumRows; n++) begin
            if (n == 96) hold_off = 1'b1;
            if (n == 120) hold_off = 1'b0;
            if (n == 260) quiet = 1'b1;
            if (n == 160) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end else if (!quiet && $urandom_range(4) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(3, 1)) @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_data  <= make_row(n);
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fails == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
